FILE: rtl/slm_pkg.sv
// Shared types and constants for the sorted-list merge block.
// No dependencies; imported by every module of the block.
`default_nettype none

package slm_pkg;

  // Default number of entries held per list
  localparam int unsigned SLM_DEPTH = 16;

  // Width of one list element
  localparam int unsigned SLM_DATA_W = 32;

  // Sequencer states: load items, then stream out the merge
  typedef enum logic {
    ST_LOAD  = 1'b0,
    ST_MERGE = 1'b1
  } slm_state_t;

  // Control from the sequencer to one list buffer
  typedef struct packed {
    logic push;   // append an item to this list (ignored once closed)
    logic close;  // the pushed item closes this list
    logic clear;  // empty the list and reopen it
  } slm_list_ctrl_t;

  // Status from one list buffer to the sequencer
  typedef struct packed {
    logic closed;
    logic full;
  } slm_list_stat_t;

endpackage

`default_nettype wire

FILE: rtl/slm_list.sv
// One list buffer of the sorted-list merge block: element store, fill count
// and closed mark. Depends on slm_pkg.
`default_nettype none

module slm_list
  import slm_pkg::*;
#(
  parameter int unsigned DEPTH = SLM_DEPTH,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1),
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire slm_list_ctrl_t        ctrl,
  input  wire logic [SLM_DATA_W-1:0] wr_data,
  input  wire logic [CNT_W-1:0]      rd_ptr,
  output logic [SLM_DATA_W-1:0]      rd_data,
  output logic [CNT_W-1:0]           count,
  output slm_list_stat_t             stat
);

  logic [SLM_DATA_W-1:0] store [DEPTH];
  logic                  closed;
  logic                  full;
  logic                  do_write;

  assign full     = (count == CNT_W'(DEPTH));
  assign do_write = ctrl.push && !closed && !full;

  // Store the element at the fill position
  always_ff @(posedge clk) begin
    if (do_write) begin
      store[count[IDX_W-1:0]] <= wr_data;
    end
  end

  // Track the fill count and the closed mark; clear wins
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      count  <= '0;
      closed <= 1'b0;
    end else if (ctrl.push && !closed) begin
      if (!full) begin
        count <= CNT_W'(count + 1'b1);
      end
      if (ctrl.close) begin
        closed <= 1'b1;
      end
    end
  end

  assign rd_data     = store[rd_ptr[IDX_W-1:0]];
  assign stat.closed = closed;
  assign stat.full   = full;

`ifndef SYNTH
  // The fill count never passes the depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("slm_list: count above depth");

  // A closed list does not grow until cleared
  a_closed_frozen: assert property (@(posedge clk) disable iff (rst)
    (closed && !ctrl.clear) |=> $stable(count))
    else $error("slm_list: closed list changed");

  // A clear empties and reopens the list
  a_clear: assert property (@(posedge clk) disable iff (rst)
    ctrl.clear |=> (count == '0 && !closed))
    else $error("slm_list: clear did not empty list");
`endif

endmodule

`default_nettype wire

FILE: rtl/sorted_list_merge.sv
// Top level of the sorted-list merge block: input handshake, merge sequencer
// and output register. Depends on slm_pkg and slm_list.
`default_nettype none

// Items tagged for list A or list B load at one per cycle while s_tready is
// high, into two buffers of DEPTH entries each; an item with tlast closes its
// list, and items for a closed list are ignored while the other list is still
// open. Items beyond DEPTH are dropped and reported on tuser of every result
// of that merge. When the item that closes the second list is taken, s_tready
// falls and a single signed comparator walks both buffers, emitting one merged
// value per cycle while the output is not stalled (list B first on ties) into
// the output register; the last result carries tlast. s_tready returns in the
// cycle after the last result is loaded, even while it still waits to be taken.
module sorted_list_merge
  import slm_pkg::*;
#(
  parameter int unsigned DEPTH = SLM_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Input stream
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic signed [SLM_DATA_W-1:0] s_tdata,   // [31:0] value
  input  wire logic                         s_tlast,   // closes_list
  input  wire logic                         s_tuser,   // [0] which_list (1 = B)
  // Output stream
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic signed [SLM_DATA_W-1:0]      m_tdata,   // [31:0] merged_value
  output logic                              m_tlast,   // final_one
  output logic                              m_tuser    // [0] dropped_flag
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  slm_state_t            state, state_next;
  slm_list_ctrl_t        ctrl_a, ctrl_b;
  slm_list_stat_t        stat_a, stat_b;
  logic [CNT_W-1:0]      count_a, count_b;
  logic [CNT_W-1:0]      ia, ia_next, ib, ib_next;
  logic [SLM_DATA_W-1:0] rd_a, rd_b;
  logic                  overflow_seen, overflow_next;
  logic                  in_acc;
  logic                  out_free;
  logic                  a_left, b_left, take_b;
  logic                  out_load;
  logic [SLM_DATA_W-1:0] out_data;
  logic                  out_last;
  logic                  close_a_now, close_b_now;

  slm_list #(.DEPTH(DEPTH)) u_list_a (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl_a),
    .wr_data (s_tdata),
    .rd_ptr  (ia),
    .rd_data (rd_a),
    .count   (count_a),
    .stat    (stat_a)
  );

  slm_list #(.DEPTH(DEPTH)) u_list_b (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl_b),
    .wr_data (s_tdata),
    .rd_ptr  (ib),
    .rd_data (rd_b),
    .count   (count_b),
    .stat    (stat_b)
  );

  assign s_tready = (state == ST_LOAD);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Shared compare unit: pick the next element of the merge
  assign a_left = (ia < count_a);
  assign b_left = (ib < count_b);
  assign take_b = !a_left || (b_left && ($signed(rd_b) <= $signed(rd_a)));

  // Closing marks as they stand after this transaction
  assign close_a_now = stat_a.closed || (in_acc && !s_tuser && s_tlast);
  assign close_b_now = stat_b.closed || (in_acc && s_tuser && s_tlast);

  // Sequencer: next state, buffer control and output load
  always_comb begin
    state_next    = state;
    ctrl_a        = '0;
    ctrl_b        = '0;
    ia_next       = ia;
    ib_next       = ib;
    overflow_next = overflow_seen;
    out_load      = 1'b0;
    out_data      = take_b ? rd_b : rd_a;
    out_last      = 1'b0;
    case (state)
      ST_LOAD: begin
        if (in_acc) begin
          ctrl_a.push  = !s_tuser;
          ctrl_a.close = s_tlast;
          ctrl_b.push  = s_tuser;
          ctrl_b.close = s_tlast;
          // Flag an item that finds its open list full
          if (s_tuser ? (!stat_b.closed && stat_b.full)
                      : (!stat_a.closed && stat_a.full)) begin
            overflow_next = 1'b1;
          end
          if (close_a_now && close_b_now) begin
            state_next = ST_MERGE;
          end
        end
        ia_next = '0;
        ib_next = '0;
      end
      ST_MERGE: begin
        if (!a_left && !b_left) begin
          // Nothing held: drop both lists without output
          ctrl_a.clear  = 1'b1;
          ctrl_b.clear  = 1'b1;
          overflow_next = 1'b0;
          state_next    = ST_LOAD;
        end else if (out_free) begin
          out_load = 1'b1;
          if (take_b) begin
            ib_next = CNT_W'(ib + 1'b1);
          end else begin
            ia_next = CNT_W'(ia + 1'b1);
          end
          out_last = (ia_next >= count_a) && (ib_next >= count_b);
          if (out_last) begin
            ctrl_a.clear  = 1'b1;
            ctrl_b.clear  = 1'b1;
            overflow_next = 1'b0;
            state_next    = ST_LOAD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // Hold state, read pointers and overflow record
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      ia            <= '0;
      ib            <= '0;
      overflow_seen <= 1'b0;
    end else begin
      state         <= state_next;
      ia            <= ia_next;
      ib            <= ib_next;
      overflow_seen <= overflow_next;
    end
  end

  // Output register: load a result, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= out_data;
      m_tlast <= out_last;
      m_tuser <= overflow_seen;
    end
  end

`ifndef SYNTH
  // Read pointers never run past the fill counts while merging
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MERGE) |-> ((ia <= count_a) && (ib <= count_b)))
    else $error("sorted_list_merge: read pointer past count");

  // Merging starts only with both lists closed
  a_merge_closed: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MERGE) |-> (stat_a.closed && stat_b.closed))
    else $error("sorted_list_merge: merge with an open list");

  // The last result returns the sequencer to loading with empty lists
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_last) |=> (state == ST_LOAD && count_a == '0 && count_b == '0))
    else $error("sorted_list_merge: lists not cleared after merge");

  // A result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("sorted_list_merge: output overwritten");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_sorted_list_merge.sv
// Testbench for sorted_list_merge: streams tagged list items, predicts the merged
// output in a behavioral model, and checks every result transaction in order.
// Depends on slm_pkg and the sorted_list_merge RTL.
`timescale 1ns / 1ps

module tb_sorted_list_merge;
  import slm_pkg::*;

  // One input item and one merged result
  typedef struct {
    bit                         to_b;
    logic signed [SLM_DATA_W-1:0] value;
    bit                         closes;
  } load_item_t;

  typedef struct {
    logic signed [SLM_DATA_W-1:0] value;
    bit                         last_one;
    bit                         dropped;
  } merge_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic signed [SLM_DATA_W-1:0] s_tdata = '0;
  logic                         s_tlast = 1'b0;
  logic                         s_tuser = 1'b0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic signed [SLM_DATA_W-1:0] m_tdata;
  logic                         m_tlast;
  logic                         m_tuser;

  load_item_t pending_q[$];
  merge_res_t merged_expect_q[$];
  load_item_t cur_item;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  int         items_queued   = 0;
  int         fail_count     = 0;

  // Behavioral copy of the list buffers
  logic signed [SLM_DATA_W-1:0] list_a[SLM_DEPTH];
  logic signed [SLM_DATA_W-1:0] list_b[SLM_DEPTH];
  int unsigned cnt_a = 0;
  int unsigned cnt_b = 0;
  bit          shut_a = 1'b0;
  bit          shut_b = 1'b0;
  bit          overflow_hit = 1'b0;

  sorted_list_merge u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Append an accepted item to its list; once both lists close, queue the merge
  task automatic apply_load_item(input load_item_t it);
    int unsigned ia;
    int unsigned ib;
    bit          take_b;
    merge_res_t  r;
    ia = 0;
    ib = 0;
    if (it.to_b) begin
      if (!shut_b) begin
        if (cnt_b < SLM_DEPTH) begin
          list_b[cnt_b] = it.value;
          cnt_b++;
        end else begin
          overflow_hit = 1'b1;
        end
        if (it.closes) shut_b = 1'b1;
      end
    end else begin
      if (!shut_a) begin
        if (cnt_a < SLM_DEPTH) begin
          list_a[cnt_a] = it.value;
          cnt_a++;
        end else begin
          overflow_hit = 1'b1;
        end
        if (it.closes) shut_a = 1'b1;
      end
    end
    if (shut_a && shut_b) begin
      // Two-pointer merge, list B wins ties
      while (ia < cnt_a || ib < cnt_b) begin
        if (ia >= cnt_a) take_b = 1'b1;
        else if (ib >= cnt_b) take_b = 1'b0;
        else take_b = (list_b[ib] <= list_a[ia]);
        if (take_b) begin
          r.value = list_b[ib];
          ib++;
        end else begin
          r.value = list_a[ia];
          ia++;
        end
        r.last_one = (ia >= cnt_a && ib >= cnt_b);
        r.dropped  = overflow_hit;
        merged_expect_q.push_back(r);
      end
      cnt_a = 0;
      cnt_b = 0;
      shut_a = 1'b0;
      shut_b = 1'b0;
      overflow_hit = 1'b0;
    end
  endtask

  task automatic push_item(input bit to_b, input logic signed [SLM_DATA_W-1:0] v,
                           input bit closes);
    load_item_t it;
    it.to_b = to_b;
    it.value = v;
    it.closes = closes;
    pending_q.push_back(it);
    items_queued++;
  endtask

  // Mix of extremes, full-range values and a narrow band that forces ties
  function automatic int rand_elem();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 0;
        default: return -1;
      endcase
    end else if (sel < 5) begin
      return $urandom;
    end
    return $urandom_range(0, 16) - 8;
  endfunction

  // One pair of lists, interleaved at random, each closed by its last element;
  // stray items for an already closed list are sprinkled in as noise
  task automatic add_merge_set(input int na, input int nb, input bit in_order);
    int qa[$];
    int qb[$];
    int ia;
    int ib;
    bit pick_b;
    ia = 0;
    ib = 0;
    repeat (na) qa.push_back(rand_elem());
    repeat (nb) qb.push_back(rand_elem());
    if (in_order) begin
      qa.sort();
      qb.sort();
    end
    while (ia < na || ib < nb) begin
      if (ia >= na) pick_b = 1'b1;
      else if (ib >= nb) pick_b = 1'b0;
      else pick_b = $urandom_range(0, 1);
      if (pick_b) begin
        push_item(1'b1, qb[ib], ib == nb - 1);
        ib++;
      end else begin
        push_item(1'b0, qa[ia], ia == na - 1);
        ia++;
      end
      if (((ia == na) != (ib == nb)) && $urandom_range(0, 5) == 0)
        push_item(ib == nb, rand_elem(), $urandom_range(0, 1));
    end
  endtask

  task automatic add_random_sets(input int target);
    int start;
    int na;
    int nb;
    start = items_queued;
    while (items_queued - start < target) begin
      na = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 18) : $urandom_range(1, 5);
      nb = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 18) : $urandom_range(1, 5);
      add_merge_set(na, nb, $urandom_range(0, 4) != 0);
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || s_tvalid || merged_expect_q.size() != 0)
      @(posedge clk);
  endtask

  // Input driver: hold each item until taken, then predict it and load the next
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) apply_load_item(cur_item);
      if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur_item = pending_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= cur_item.value;
        s_tlast  <= cur_item.closes;
        s_tuser  <= cur_item.to_b;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    merge_res_t exp_r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (merged_expect_q.size() == 0) begin
          $display("%0t: unexpected result value=%0d last=%0b dropped=%0b",
                   $time, m_tdata, m_tlast, m_tuser);
          fail_count++;
        end else begin
          exp_r = merged_expect_q.pop_front();
          if (m_tdata !== exp_r.value || m_tlast !== exp_r.last_one ||
              m_tuser !== exp_r.dropped) begin
            $display("%0t: mismatch expected value=%0d last=%0b dropped=%0b",
                     $time, exp_r.value, exp_r.last_one, exp_r.dropped);
            $display("%0t:          actual   value=%0d last=%0b dropped=%0b",
                     $time, m_tdata, m_tlast, m_tuser);
            fail_count++;
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Stimulus and phase sequencing
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Extremes on both lists
    push_item(1'b0, 32'h8000_0000, 1'b1);
    push_item(1'b1, 32'h7FFF_FFFF, 1'b1);
    // Ties, B closing first, and items for a closed list that must be ignored
    push_item(1'b1, -1, 1'b0);
    push_item(1'b0, 0, 1'b0);
    push_item(1'b1, 0, 1'b1);
    push_item(1'b1, 5, 1'b0);
    push_item(1'b1, 9, 1'b1);
    push_item(1'b0, 0, 1'b0);
    push_item(1'b0, 32'h7FFF_FFFF, 1'b1);
    // Single-element tie
    push_item(1'b0, -3, 1'b1);
    push_item(1'b1, -3, 1'b1);
    // Repeated minimum on both lists
    push_item(1'b1, 32'h8000_0000, 1'b0);
    push_item(1'b1, 32'h8000_0000, 1'b1);
    push_item(1'b0, 32'h8000_0000, 1'b0);
    push_item(1'b0, 1, 1'b1);
    add_random_sets(40);
    wait_drained();

    send_idle_pct = 71;
    add_random_sets(40);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 71;
    add_random_sets(40);
    wait_drained();

    send_idle_pct  = 38;
    recv_stall_pct = 38;
    add_random_sets(40);
    wait_drained();

    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
